// ===== src/markup_escape_parser_assert.svh =====
// Assertion macros for the parser's RTL files; mep_queue includes them.
// Expects i_clk and active-low i_rst_n in the including module.
`ifndef MARKUP_ESCAPE_PARSER_ASSERT_SVH
`define MARKUP_ESCAPE_PARSER_ASSERT_SVH

// Property checked every cycle outside reset.
`define MEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition this cycle implies expression next cycle.
`define MEP_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/mep_pkg.sv =====
// Shared types, constants and command table for the markup escape parser.
// No dependencies.
package mep_pkg;

    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [7:0]  CH_BACKTICK = 8'h60;
    localparam logic [7:0]  CH_HASH     = 8'h23;
    localparam logic [7:0]  CH_DASH     = 8'h2D;
    localparam logic [31:0] REPLACEMENT = 32'h0000_FFFD;
    localparam logic [2:0]  HASH_DIGITS = 3'd6;

    localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd80;
    localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd25;
    localparam logic [31:0] RST_DEFAULT_COLOR = 32'h0100_0000;
    localparam logic [31:0] RST_PALETTE_FLAG  = 32'h0200_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 8'd0,
        REG_SCREEN_HEIGHT = 8'd1,
        REG_DEFAULT_COLOR = 8'd2,
        REG_PALETTE_FLAG  = 8'd3
    } t_reg_idx;

    // finalizer kinds
    typedef enum logic [3:0] {
        K_XPOS, K_XNEG, K_XCEN, K_YPOS, K_YNEG, K_YCEN, K_FG, K_BG, K_DFG,
        K_DBG, K_BORDER, K_ATTR, K_RESET, K_CLREOL, K_CLRSCR, K_CHAR
    } t_kind;

    // emitted action codes
    typedef enum logic [3:0] {
        ACT_CHAR   = 4'd0,
        ACT_SETX   = 4'd1,
        ACT_SETY   = 4'd2,
        ACT_FG     = 4'd3,
        ACT_BG     = 4'd4,
        ACT_DEFFG  = 4'd5,
        ACT_DEFBG  = 4'd6,
        ACT_BORDER = 4'd7,
        ACT_ATTR   = 4'd8,
        ACT_RESET  = 4'd9,
        ACT_CLREOL = 4'd10,
        ACT_CLRSCR = 4'd11
    } t_action;

    typedef enum logic [1:0] {
        BASE_RAW, BASE_DEC, BASE_HEX
    } t_base;

    typedef struct packed {
        logic       color_cmd;
        logic       plus;
        logic [2:0] digits;
        t_base      base;
        t_kind      kind;
    } t_cmd_info;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_lookup;

    // one finished sequence, handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic        on;
    } t_qitem;

    function automatic t_lookup cmd_lookup(input logic [7:0] c);
        t_lookup r;
        r.hit = 1'b1;
        case (c)
            "x":     r.idx = 5'd0;
            "X":     r.idx = 5'd1;
            "c":     r.idx = 5'd2;
            "y":     r.idx = 5'd3;
            "Y":     r.idx = 5'd4;
            "C":     r.idx = 5'd5;
            "f":     r.idx = 5'd6;
            "b":     r.idx = 5'd7;
            "F":     r.idx = 5'd8;
            "B":     r.idx = 5'd9;
            "r":     r.idx = 5'd10;
            "-":     r.idx = 5'd11;
            "+":     r.idx = 5'd12;
            "0":     r.idx = 5'd13;
            "z":     r.idx = 5'd14;
            "Z":     r.idx = 5'd15;
            "u":     r.idx = 5'd16;
            "U":     r.idx = 5'd17;
            default: begin
                r.hit = 1'b0;
                r.idx = 5'd0;
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd_info cmd_info(input logic [4:0] idx);
        t_cmd_info r;
        case (idx)
            5'd1:    r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_XNEG};
            5'd2:    r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_XCEN};
            5'd3:    r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_YPOS};
            5'd4:    r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_YNEG};
            5'd5:    r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_YCEN};
            5'd6:    r = '{1'b1, 1'b0, 3'd1, BASE_HEX, K_FG};
            5'd7:    r = '{1'b1, 1'b0, 3'd1, BASE_HEX, K_BG};
            5'd8:    r = '{1'b1, 1'b0, 3'd1, BASE_HEX, K_DFG};
            5'd9:    r = '{1'b1, 1'b0, 3'd1, BASE_HEX, K_DBG};
            5'd10:   r = '{1'b1, 1'b0, 3'd1, BASE_HEX, K_BORDER};
            5'd11:   r = '{1'b0, 1'b0, 3'd1, BASE_RAW, K_ATTR};
            5'd12:   r = '{1'b0, 1'b1, 3'd1, BASE_RAW, K_ATTR};
            5'd13:   r = '{1'b0, 1'b0, 3'd0, BASE_RAW, K_RESET};
            5'd14:   r = '{1'b0, 1'b0, 3'd0, BASE_RAW, K_CLREOL};
            5'd15:   r = '{1'b0, 1'b0, 3'd0, BASE_RAW, K_CLRSCR};
            5'd16:   r = '{1'b0, 1'b0, 3'd4, BASE_HEX, K_CHAR};
            5'd17:   r = '{1'b0, 1'b0, 3'd6, BASE_HEX, K_CHAR};
            default: r = '{1'b0, 1'b0, 3'd2, BASE_DEC, K_XPOS};
        endcase
        return r;
    endfunction

endpackage

// ===== src/mep_front.sv =====
// Front end: per-byte sequence state, command match and digit gathering.
// Depends on mep_pkg.
module mep_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte_in,
    input  logic [31:0]       i_default_color,
    input  logic [31:0]       i_palette_flag,
    output logic              o_push,
    output mep_pkg::t_qitem   o_item
);
    import mep_pkg::*;

    logic        r_in_seq,  n_in_seq;
    logic [4:0]  r_cmd,     n_cmd;
    logic [2:0]  r_digits,  n_digits;
    logic        r_at2,     n_at2;
    logic [31:0] r_acc,     n_acc;

    t_cmd_info   info;
    t_cmd_info   new_info;
    t_lookup     lk;
    logic [5:0]  dval;
    logic        dbad;
    logic [31:0] acc_step;
    logic [2:0]  dl;

    assign info     = cmd_info(r_cmd);
    assign lk       = cmd_lookup(i_byte_in);
    assign new_info = cmd_info(lk.idx);
    assign dl       = r_digits - 3'd1;

    // digit value, 63 when not a letter or number
    always_comb begin
        if (i_byte_in >= "0" && i_byte_in <= "9") begin
            dval = 6'(i_byte_in - "0");
        end else if (i_byte_in >= "A" && i_byte_in <= "Z") begin
            dval = 6'(i_byte_in - "A" + 8'd10);
        end else if (i_byte_in >= "a" && i_byte_in <= "z") begin
            dval = 6'(i_byte_in - "a" + 8'd10);
        end else begin
            dval = 6'd63;
        end
        case (info.base)
            BASE_DEC: dbad = (dval >= 6'd10);
            BASE_HEX: dbad = (dval >= 6'd16);
            default:  dbad = 1'b0;
        endcase
        case (info.base)
            BASE_DEC: acc_step = (r_acc << 3) + (r_acc << 1) + {26'd0, dval};
            BASE_HEX: acc_step = (r_acc << 4) | {26'd0, dval};
            default:  acc_step = {r_acc[23:0], i_byte_in};
        endcase
    end

    always_comb begin
        n_in_seq = r_in_seq;
        n_cmd    = r_cmd;
        n_digits = r_digits;
        n_at2    = r_at2;
        n_acc    = r_acc;
        o_push   = 1'b0;
        o_item   = '{K_CHAR, REPLACEMENT, 1'b0};
        if (i_accept) begin
            if (!r_in_seq) begin
                if (i_byte_in == CH_BACKTICK) begin
                    o_push = 1'b1;
                    o_item = '{K_CHAR, {24'd0, i_byte_in}, 1'b0};
                end else if (!lk.hit) begin
                    o_push = 1'b1;
                end else begin
                    n_cmd    = lk.idx;
                    n_acc    = '0;
                    n_digits = new_info.digits;
                    if (new_info.digits == 3'd0) begin
                        o_push = 1'b1;
                        o_item = '{new_info.kind, 32'd0, 1'b0};
                    end else begin
                        n_in_seq = 1'b1;
                        n_at2    = 1'b1;
                    end
                end
            end else if (info.color_cmd && r_at2 && i_byte_in == CH_DASH) begin
                o_push   = 1'b1;
                o_item   = '{info.kind, i_default_color, 1'b0};
                n_acc    = i_default_color;
                n_in_seq = 1'b0;
                n_at2    = 1'b0;
                n_digits = '0;
            end else if (info.color_cmd && r_at2 && i_byte_in == CH_HASH) begin
                n_digits = HASH_DIGITS;
                n_at2    = 1'b0;
            end else if (info.base != BASE_RAW && dbad) begin
                o_push   = 1'b1;
                n_in_seq = 1'b0;
                n_at2    = 1'b0;
                n_digits = '0;
            end else if (dl != 3'd0) begin
                n_acc    = acc_step;
                n_digits = dl;
                n_at2    = 1'b0;
            end else begin
                // last digit: single-digit colors pick up the palette flag
                n_acc    = acc_step | ((info.color_cmd && r_at2) ? i_palette_flag : 32'd0);
                o_push   = 1'b1;
                o_item   = '{info.kind, n_acc, info.plus};
                n_in_seq = 1'b0;
                n_at2    = 1'b0;
                n_digits = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq <= 1'b0;
            r_cmd    <= '0;
            r_digits <= '0;
            r_at2    <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_in_seq <= n_in_seq;
            r_cmd    <= n_cmd;
            r_digits <= n_digits;
            r_at2    <= n_at2;
            r_acc    <= n_acc;
        end
    end

endmodule

// ===== src/mep_queue.sv =====
// Short register queue between the front and back ends.
// Depends on mep_pkg and markup_escape_parser_assert.svh.
`include "markup_escape_parser_assert.svh"

module mep_queue #(
    parameter int unsigned DEPTH = mep_pkg::Q_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mep_pkg::t_qitem i_item,
    input  logic            i_pop,
    output mep_pkg::t_qitem o_item,
    output logic            o_full,
    output logic            o_empty
);
    import mep_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_qitem            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MEP_ASSERT(a_no_overflow, i_push |-> !o_full, "queue push while full")
    `MEP_ASSERT(a_no_underflow, i_pop |-> !o_empty, "queue pop while empty")
    `MEP_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "bad count")
    `MEP_ASSERT_NEXT(a_count_down, i_pop && !i_push, r_count == $past(r_count) - 1'b1, "bad count")

endmodule

// ===== src/mep_back.sv =====
// Back end: turns queued sequences into actions, owns the output register.
// Depends on mep_pkg.
module mep_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mep_pkg::t_qitem i_item,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic [15:0]     i_screen_width,
    input  logic [15:0]     i_screen_height,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [3:0]      o_action,
    output logic [31:0]     o_value,
    output logic            o_attribute_on
);
    import mep_pkg::*;

    logic        r_valid;
    logic [3:0]  r_action;
    logic [31:0] r_value;
    logic        r_on;

    t_action     act;
    logic [31:0] val;
    logic        on;
    logic        load;
    logic [15:0] size;
    logic        clamp0;
    logic [15:0] diff;
    logic        attr_hit;
    logic [2:0]  attr_idx;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !i_empty;

    // clamped distance from the far edge
    always_comb begin
        case (i_item.kind)
            K_YNEG, K_YCEN: size = i_screen_height;
            default:        size = i_screen_width;
        endcase
        clamp0 = (i_item.value >= {16'd0, size});
        diff   = size - i_item.value[15:0];
    end

    always_comb begin
        attr_hit = (i_item.value[31:8] == 24'd0);
        case (i_item.value[7:0])
            "B", "b": attr_idx = 3'd0;
            "D", "d": attr_idx = 3'd1;
            "U", "u": attr_idx = 3'd2;
            "F", "f": attr_idx = 3'd3;
            "R", "r": attr_idx = 3'd4;
            "I", "i": attr_idx = 3'd5;
            default: begin
                attr_idx = 3'd0;
                attr_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        act = ACT_CHAR;
        val = i_item.value;
        on  = 1'b0;
        case (i_item.kind)
            K_XPOS: begin
                act = ACT_SETX;
                val = {16'd0, i_item.value[15:0]};
            end
            K_XNEG: begin
                act = ACT_SETX;
                val = clamp0 ? 32'd0 : {16'd0, diff};
            end
            K_XCEN: begin
                act = ACT_SETX;
                val = clamp0 ? 32'd0 : {17'd0, diff[15:1]};
            end
            K_YPOS: begin
                act = ACT_SETY;
                val = {16'd0, i_item.value[15:0]};
            end
            K_YNEG: begin
                act = ACT_SETY;
                val = clamp0 ? 32'd0 : {16'd0, diff};
            end
            K_YCEN: begin
                act = ACT_SETY;
                val = clamp0 ? 32'd0 : {17'd0, diff[15:1]};
            end
            K_FG:     act = ACT_FG;
            K_BG:     act = ACT_BG;
            K_DFG:    act = ACT_DEFFG;
            K_DBG:    act = ACT_DEFBG;
            K_BORDER: act = ACT_BORDER;
            K_ATTR: begin
                if (attr_hit) begin
                    act = ACT_ATTR;
                    val = {29'd0, attr_idx};
                    on  = i_item.on;
                end else begin
                    val = REPLACEMENT;
                end
            end
            K_RESET: begin
                act = ACT_RESET;
                val = '0;
            end
            K_CLREOL: begin
                act = ACT_CLREOL;
                val = '0;
            end
            K_CLRSCR: begin
                act = ACT_CLRSCR;
                val = '0;
            end
            default: act = ACT_CHAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= act;
            r_value  <= val;
            r_on     <= on;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_action       = r_action;
    assign o_value        = r_value;
    assign o_attribute_on = r_on;

endmodule

// ===== src/markup_escape_parser.sv =====
// Top level of the markup escape parser: config registers and the
// front / queue / back chain. Depends on mep_pkg, mep_front, mep_queue, mep_back.
//
// Usage:
//   Input channel: one byte per transfer (i_in_valid / o_in_stall), the bytes
//   that follow a backtick introducer. Output channel: one action per
//   finished sequence (o_out_valid / i_out_stall) with value and
//   attribute_on. Bytes that only extend a sequence produce nothing.
//   Config channel: i_cfg_valid with i_cfg_index / i_cfg_data, always ready;
//   index 0 width, 1 height, 2 default color, 3 palette flag, others ignored.
//   Write config only while the parser is idle.
// Timing:
//   A byte that ends a sequence goes into the queue at its transfer edge;
//   the back end moves it to the output register once that register is free
//   and earlier entries have left. Sustained rate is one byte per cycle while
//   the queue is not full. The front stalls only when the queue (QDEPTH entries)
//   is full, which happens when the output side stalls; a full output register
//   plus a full queue hold QDEPTH+1 pending actions.
// Reset: synchronous, active low; clears sequence state, queue and output
//   valid, and loads the config registers with their defaults.
module markup_escape_parser #(
    parameter int unsigned QDEPTH = mep_pkg::Q_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_byte_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [3:0]                     o_action,
    output logic [31:0]                    o_value,
    output logic                           o_attribute_on,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mep_pkg::*;

    logic [15:0] r_screen_width;
    logic [15:0] r_screen_height;
    logic [31:0] r_default_color;
    logic [31:0] r_palette_flag;

    logic        in_accept;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    t_qitem      front_item;
    t_qitem      back_item;

    // config writes are always accepted and registered
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_default_color <= RST_DEFAULT_COLOR;
            r_palette_flag  <= RST_PALETTE_FLAG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[15:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[15:0];
                REG_DEFAULT_COLOR: r_default_color <= i_cfg_data;
                REG_PALETTE_FLAG:  r_palette_flag  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // front stalls only on a full queue; independent of the output stall
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    mep_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_byte_in       (i_byte_in),
        .i_default_color (r_default_color),
        .i_palette_flag  (r_palette_flag),
        .o_push          (q_push),
        .o_item          (front_item)
    );

    mep_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (back_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mep_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (back_item),
        .i_empty         (q_empty),
        .o_pop           (q_pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action        (o_action),
        .o_value         (o_value),
        .o_attribute_on  (o_attribute_on)
    );

endmodule

// ===== tb/markup_escape_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for markup_escape_parser: queue-fed byte driver, clocked
// output monitor and an in-bench copy of the escape parser's behavior.
// Depends on mep_pkg and the markup_escape_parser RTL.
module markup_escape_parser_tb;
    import mep_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 60;   // long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 4;    // pause after the bench drains
    localparam int unsigned PHASE_BYTES   = 400;
    localparam logic [7:0]  BACKTICK      = 8'h60;
    localparam logic [31:0] BAD_CHAR      = 32'h0000_FFFD;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 8'd200;  // index with no register

    typedef struct packed {
        t_action     act;
        logic [31:0] value;
        logic        on;
    } t_exp_action;

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_byte_in      = 8'h00;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [3:0]            o_action;
    logic [31:0]           o_value;
    logic                  o_attribute_on;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    markup_escape_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_byte_in      (i_byte_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_action       (o_action),
        .o_value        (o_value),
        .o_attribute_on (o_attribute_on),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [7:0]  byte_q[$];          // bytes waiting for the driver
    t_exp_action expected_actions[$];
    bit          in_taken;           // byte transfer at the last rising edge
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req  = 0;      // bumped by stimulus to ask for a hold-off
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_taken    = 0;
    int unsigned actions_seen   = 0;
    int unsigned stall_cycles   = 0;
    int unsigned settings_count = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    string cmd_letters  = "xXcyYCfbFBr-+0zZuU";
    string attr_letters = "BbDdUuFfRrIi";
    string hex_letters  = "0123456789abcdefABCDEF";

    // Mirror of the block: config copy plus sequence state
    logic [15:0] mirror_width   = 16'd80;
    logic [15:0] mirror_height  = 16'd25;
    logic [31:0] mirror_default = 32'h0100_0000;
    logic [31:0] mirror_palette = 32'h0200_0000;
    bit          seq_open  = 1'b0;   // command letter seen, arguments pending
    bit          first_arg = 1'b0;   // next byte is the first after the letter
    logic [7:0]  cur_cmd   = 8'h00;
    logic [2:0]  args_left = 3'd0;
    logic [31:0] acc       = 32'd0;

    // ------------------------------------------------------------------
    // Command properties
    // ------------------------------------------------------------------
    function automatic bit is_command(input logic [7:0] c);
        case (c)
            "x", "X", "c", "y", "Y", "C", "f", "b", "F", "B", "r",
            "-", "+", "0", "z", "Z", "u", "U": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit has_color_arg(input logic [7:0] c);
        case (c)
            "f", "b", "F", "B", "r": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] arg_count(input logic [7:0] c);
        case (c)
            "x", "X", "c", "y", "Y", "C": return 3'd2;
            "f", "b", "F", "B", "r", "-", "+": return 3'd1;
            "u": return 3'd4;
            "U": return 3'd6;
            default: return 3'd0;
        endcase
    endfunction

    // 0 means the argument is a raw byte
    function automatic int unsigned arg_radix(input logic [7:0] c);
        case (c)
            "x", "X", "c", "y", "Y", "C": return 10;
            "f", "b", "F", "B", "r", "u", "U": return 16;
            default: return 0;
        endcase
    endfunction

    // distance from the far edge, zero once n reaches the screen size
    function automatic logic [31:0] clamp_dist(input logic [15:0] size, input logic [31:0] n,
                                               input bit halve);
        logic [31:0] d;
        if (n >= {16'd0, size})
            return 32'd0;
        d = {16'd0, size} - n;
        return halve ? (d >> 1) : d;
    endfunction

    function automatic void expect_action(input t_action a, input logic [31:0] v,
                                          input logic on);
        t_exp_action r;
        r.act   = a;
        r.value = v;
        r.on    = on;
        expected_actions.push_back(r);
        seq_open  = 1'b0;
        first_arg = 1'b0;
        args_left = 3'd0;
    endfunction

    // Turn the gathered argument into the action of the current command
    function automatic void close_sequence();
        logic on;
        on = (cur_cmd == "+");
        case (cur_cmd)
            "x": expect_action(ACT_SETX, acc & 32'hFFFF, 1'b0);
            "X": expect_action(ACT_SETX, clamp_dist(mirror_width, acc, 1'b0), 1'b0);
            "c": expect_action(ACT_SETX, clamp_dist(mirror_width, acc, 1'b1), 1'b0);
            "y": expect_action(ACT_SETY, acc & 32'hFFFF, 1'b0);
            "Y": expect_action(ACT_SETY, clamp_dist(mirror_height, acc, 1'b0), 1'b0);
            "C": expect_action(ACT_SETY, clamp_dist(mirror_height, acc, 1'b1), 1'b0);
            "f": expect_action(ACT_FG, acc, 1'b0);
            "b": expect_action(ACT_BG, acc, 1'b0);
            "F": expect_action(ACT_DEFFG, acc, 1'b0);
            "B": expect_action(ACT_DEFBG, acc, 1'b0);
            "r": expect_action(ACT_BORDER, acc, 1'b0);
            "-", "+": begin
                case (acc)
                    "B", "b": expect_action(ACT_ATTR, 32'd0, on);
                    "D", "d": expect_action(ACT_ATTR, 32'd1, on);
                    "U", "u": expect_action(ACT_ATTR, 32'd2, on);
                    "F", "f": expect_action(ACT_ATTR, 32'd3, on);
                    "R", "r": expect_action(ACT_ATTR, 32'd4, on);
                    "I", "i": expect_action(ACT_ATTR, 32'd5, on);
                    default:  expect_action(ACT_CHAR, BAD_CHAR, 1'b0);
                endcase
            end
            "0": expect_action(ACT_RESET, 32'd0, 1'b0);
            "z": expect_action(ACT_CLREOL, 32'd0, 1'b0);
            "Z": expect_action(ACT_CLRSCR, 32'd0, 1'b0);
            default: expect_action(ACT_CHAR, acc, 1'b0);   // u and U code points
        endcase
    endfunction

    // Advance the mirror by one transferred byte, queueing any action it ends
    function automatic void parse_byte(input logic [7:0] c);
        int unsigned radix;
        logic [31:0] digit;
        if (!seq_open) begin
            if (c == BACKTICK) begin
                expect_action(ACT_CHAR, {24'd0, BACKTICK}, 1'b0);
            end else if (!is_command(c)) begin
                expect_action(ACT_CHAR, BAD_CHAR, 1'b0);
            end else begin
                cur_cmd   = c;
                acc       = 32'd0;
                args_left = arg_count(c);
                if (args_left == 3'd0) begin
                    close_sequence();
                end else begin
                    seq_open  = 1'b1;
                    first_arg = 1'b1;
                end
            end
            return;
        end
        // colour commands: dash picks the default, hash switches to six hex digits
        if (has_color_arg(cur_cmd) && first_arg) begin
            if (c == "-") begin
                acc = mirror_default;
                close_sequence();
                return;
            end
            if (c == "#") begin
                args_left = 3'd6;
                first_arg = 1'b0;
                return;
            end
        end
        if (args_left != 3'd0) begin
            radix = arg_radix(cur_cmd);
            if (radix != 0) begin
                if (c >= "0" && c <= "9")
                    digit = c - "0";
                else if (c >= "A" && c <= "Z")
                    digit = c - "A" + 10;
                else if (c >= "a" && c <= "z")
                    digit = c - "a" + 10;
                else
                    digit = 32'hFF;
                if (digit >= radix) begin
                    expect_action(ACT_CHAR, BAD_CHAR, 1'b0);
                    return;
                end
                acc = acc * radix + digit;
            end else begin
                acc = (acc << 8) | {24'd0, c};
            end
            args_left = args_left - 3'd1;
        end
        if (args_left != 3'd0) begin
            first_arg = 1'b0;
            return;
        end
        // a lone digit right after a colour letter is a palette index
        if (has_color_arg(cur_cmd) && first_arg)
            acc = acc | mirror_palette;
        close_sequence();
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, keeps a stalled byte steady
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        if (!i_in_valid || in_taken) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_byte_in  <= byte_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    always @(negedge i_clk) begin : receiver
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left    = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on byte transfers, check action transfers in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_exp_action want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_taken    = 1'b1;
                bytes_taken = bytes_taken + 1;
                parse_byte(i_byte_in);
            end
            if (i_in_valid && o_in_stall)
                stall_cycles = stall_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                actions_seen = actions_seen + 1;
                if (expected_actions.size() == 0) begin
                    $error("unexpected action %0d, value %h", o_action, o_value);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_actions.pop_front();
                    if (o_action !== want.act) begin
                        $error("action: expected %0d, got %0d", want.act, o_action);
                        fail_count = fail_count + 1;
                    end
                    if (o_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, o_value);
                        fail_count = fail_count + 1;
                    end
                    if (o_attribute_on !== want.on) begin
                        $error("attribute_on: expected %0d, got %0d", want.on, o_attribute_on);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        byte_q.push_back(b);
        bytes_queued = bytes_queued + 1;
    endfunction

    function automatic logic [7:0] dec_char();
        return 8'h30 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] hex_char();
        return hex_letters[$urandom_range(21)];
    endfunction

    // One escape sequence: mostly well formed, some noise and broken arguments
    task automatic queue_sequence();
        logic [7:0]  cmd;
        logic [7:0]  args[$];
        int unsigned roll;
        int          k;
        roll = $urandom_range(99);
        if (roll < 8) begin
            queue_byte(8'($urandom_range(255)));
            return;
        end
        if (roll < 12) begin
            queue_byte(BACKTICK);
            return;
        end
        cmd = cmd_letters[$urandom_range(17)];
        queue_byte(cmd);
        case (cmd)
            "x", "X", "c", "y", "Y", "C": repeat (2) args.push_back(dec_char());
            "f", "b", "F", "B", "r": begin
                case ($urandom_range(2))
                    0: args.push_back("-");
                    1: begin
                        args.push_back("#");
                        repeat (6) args.push_back(hex_char());
                    end
                    default: args.push_back(hex_char());
                endcase
            end
            "-", "+": args.push_back(attr_letters[$urandom_range(11)]);
            "u": repeat (4) args.push_back(hex_char());
            "U": repeat (6) args.push_back(hex_char());
            default: ;
        endcase
        // break an argument now and then with an arbitrary byte
        if (args.size() != 0 && $urandom_range(99) < 8)
            args[$urandom_range(args.size() - 1)] = 8'($urandom_range(255));
        for (k = 0; k < args.size(); k++)
            queue_byte(args[k]);
    endtask

    task automatic queue_random(input int unsigned n);
        int unsigned target;
        target = bytes_queued + n;
        while (bytes_queued < target)
            queue_sequence();
    endtask

    // Sender pause: everything sent and every action back, then settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_q.size() != 0 || i_in_valid || expected_actions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves valid high so back-to-back writes need one assignment per edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            REG_SCREEN_WIDTH:  mirror_width   = data[15:0];
            REG_SCREEN_HEIGHT: mirror_height  = data[15:0];
            REG_DEFAULT_COLOR: mirror_default = data;
            REG_PALETTE_FLAG:  mirror_palette = data;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [31:0] w, input logic [31:0] h,
                                  input logic [31:0] dflt, input logic [31:0] pal);
        cfg_write(REG_SCREEN_WIDTH, w);
        cfg_write(REG_SCREEN_HEIGHT, h);
        cfg_write(REG_DEFAULT_COLOR, dflt);
        cfg_write(REG_PALETTE_FLAG, pal);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings_count = settings_count + 1;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        string directed;
        int    i;
        directed = "QX99c00f7b-r#Ff00a9+i-qZug";

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: doubled backtick, unknown letter, clamped
        // and centred x, palette, dash and hash colours, both attribute forms
        // with an unknown letter, a no-argument command and a bad hex digit.
        settings_count = 1;
        queue_byte(BACKTICK);
        for (i = 0; i < directed.len(); i++)
            queue_byte(directed[i]);
        wait_idle();

        // Zero width, full height, all-ones default, no palette flag
        write_settings(32'd0, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_idle_pct = 31;
        recv_idle_pct = 86;
        // pause in the middle of a code point sequence, then finish it
        queue_byte("u");
        queue_byte("1");
        queue_byte("2");
        wait_idle();
        queue_byte("3");
        queue_byte("a");
        queue_random(PHASE_BYTES);
        wait_idle();

        // Upper data bits set on the 16-bit registers; they must be dropped
        write_settings(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_idle_pct = 86;
        recv_idle_pct = 31;
        queue_random(PHASE_BYTES);
        wait_idle();

        // Small screen so the clamp goes both ways, random colour words
        write_settings($urandom_range(120, 1), $urandom_range(60, 1), $urandom, $urandom);
        cfg_write(UNUSED_REG, $urandom);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold the output long enough to fill the queue behind it
        hold_req = hold_req + 1;
        for (i = 0; i < 40; i++)
            queue_byte((i % 3 == 0) ? 8'h7A : BACKTICK);
        queue_random(PHASE_BYTES);
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d bytes and %0d actions under %0d register settings,",
                 bytes_taken, actions_seen, settings_count);
        $display("with the input held back for %0d cycles.", stall_cycles);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
